[rtl/scc_pkg.sv]
// Shared constants and types for the strongly connected components core.
`default_nettype none
package scc_pkg;
	localparam int MaxNodes = 64;
	localparam int NodeW = 6;
	localparam int CountW = 7;
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
	localparam logic [1:0] CMD_RUN = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	typedef logic [NodeW-1:0] node_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [MaxNodes-1:0] row_t;
endpackage
`default_nettype wire

[rtl/scc_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module scc_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/strongly_connected_components_core.sv]
// Top level of the strongly connected components core.
// Usage:
//   Input channel (in_valid/in_stall): command, source_node, target_node.
//   Clear drops every row at once through a valid flag per row.
//   Add edge is a read-modify-write of one row; an edge with an
//   end at or above node_count (0 counts as 1) is dropped in the accepting cycle.
//   Run performs an iterative depth-first search over the adjacency memory.
//   The neighbour scan tests one candidate index a cycle; each edge found
//   adds an order lookup, a frame write and a refetch of frame and row,
//   and each node adds finishing, popping and return. Results then leave
//   on the output channel (out_valid/out_stall), one per node in index
//   order, with last on the final node. A stalled result holds its
//   payload until transferred.
//   Configuration channel (cfg_valid/cfg_ready) writes node_count; it is
//   ready when the core is idle and no result is waiting.
//   Asynchronous reset empties the graph via a flag per row that reads as
//   no edges, sets node_count to 64 and returns to idle.
//   One item is handled at a time; the input stalls until it is finished.
`default_nettype none
module strongly_connected_components_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] command,
	input wire scc_pkg::node_t source_node,
	input wire scc_pkg::node_t target_node,
	output logic out_valid,
	input wire logic out_stall,
	output scc_pkg::node_t node_index,
	output scc_pkg::node_t component_id,
	output scc_pkg::count_t component_total,
	output logic last,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire scc_pkg::count_t cfg_data
);
	import scc_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ADD_RD = 4'd1;
	localparam logic [3:0] ST_ADD_WR = 4'd2;
	localparam logic [3:0] ST_ROOT = 4'd3;
	localparam logic [3:0] ST_FRAME = 4'd4;
	localparam logic [3:0] ST_SCAN = 4'd5;
	localparam logic [3:0] ST_LOW_RD = 4'd6;
	localparam logic [3:0] ST_LOW_CMP = 4'd7;
	localparam logic [3:0] ST_FIN = 4'd8;
	localparam logic [3:0] ST_POP = 4'd9;
	localparam logic [3:0] ST_POP_WR = 4'd10;
	localparam logic [3:0] ST_RET = 4'd11;
	localparam logic [3:0] ST_EMIT_RD = 4'd12;
	localparam logic [3:0] ST_EMIT = 4'd13;
	localparam logic [3:0] ST_CLEAR = 4'd14;

	logic [3:0] state_q;
	count_t node_count_q;
	count_t n_eff;
	row_t row_valid_q;
	row_t visited_q;
	count_t visit_q, comp_q;
	count_t fdepth_q, pdepth_q;
	count_t root_q, scan_q, emit_q;
	node_t cur_q;
	count_t fmin_q;
	node_t found_q;
	count_t lowv_q;
	node_t src_q, dst_q;
	row_t row_q;

	// adjacency memory
	logic adj_we;
	node_t adj_waddr, adj_raddr;
	row_t adj_wdata, adj_rdata;
	// lowest order memory
	logic low_we;
	node_t low_waddr, low_raddr;
	count_t low_wdata, low_rdata;
	// component memory
	logic comp_we;
	node_t comp_waddr, comp_raddr;
	node_t comp_wdata, comp_rdata;
	// pending stack
	logic pend_we;
	node_t pend_waddr, pend_raddr;
	node_t pend_wdata, pend_rdata;
	// frame stack: node, next, min
	localparam int FrameW = NodeW + 2*CountW;
	logic frm_we;
	node_t frm_waddr, frm_raddr;
	logic [FrameW-1:0] frm_wdata, frm_rdata;

	scc_ram #(.Width(MaxNodes), .Depth(MaxNodes)) u_adj (.clk(clk), .we(adj_we),
		.waddr(adj_waddr), .wdata(adj_wdata), .raddr(adj_raddr), .rdata(adj_rdata));
	scc_ram #(.Width(CountW), .Depth(MaxNodes)) u_low (.clk(clk), .we(low_we),
		.waddr(low_waddr), .wdata(low_wdata), .raddr(low_raddr), .rdata(low_rdata));
	scc_ram #(.Width(NodeW), .Depth(MaxNodes)) u_comp (.clk(clk), .we(comp_we),
		.waddr(comp_waddr), .wdata(comp_wdata), .raddr(comp_raddr), .rdata(comp_rdata));
	scc_ram #(.Width(NodeW), .Depth(MaxNodes)) u_pend (.clk(clk), .we(pend_we),
		.waddr(pend_waddr), .wdata(pend_wdata), .raddr(pend_raddr), .rdata(pend_rdata));
	scc_ram #(.Width(FrameW), .Depth(MaxNodes)) u_frm (.clk(clk), .we(frm_we),
		.waddr(frm_waddr), .wdata(frm_wdata), .raddr(frm_raddr), .rdata(frm_rdata));

	always_comb begin
		n_eff = node_count_q;
		if (node_count_q == '0) begin
			n_eff = count_t'(1);
		end else if (node_count_q > count_t'(MaxNodes)) begin
			n_eff = count_t'(MaxNodes);
		end
	end

	logic in_xfer, out_xfer, emit_fire;
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer = in_valid && !in_stall;
	assign cfg_ready = (state_q == ST_IDLE) && !out_valid;
	assign out_xfer = out_valid && !out_stall;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid || out_xfer);

	// row as seen by the search: stale/invalid rows read empty, bits past n ignored
	row_t row_eff;
	always_comb begin
		row_eff = row_valid_q[cur_q] ? adj_rdata : '0;
	end

	// top-of-frame-stack field helpers
	logic [FrameW-1:0] frm_top;
	node_t top_node;
	count_t top_next, top_min;
	assign frm_top = frm_rdata;
	assign top_node = frm_top[FrameW-1 -: NodeW];
	assign top_next = frm_top[2*CountW-1 -: CountW];
	assign top_min = frm_top[CountW-1:0];

	node_t fd_idx, fd_m1, pd_idx, pd_m1;
	assign fd_idx = fdepth_q[NodeW-1:0];
	assign fd_m1 = NodeW'(fdepth_q - count_t'(1));
	assign pd_idx = pdepth_q[NodeW-1:0];
	assign pd_m1 = NodeW'(pdepth_q - count_t'(1));

	count_t next_q;
	logic enter_q;
	node_t enter_node_q;

	always_comb begin
		adj_we = 1'b0; adj_waddr = src_q; adj_wdata = '0; adj_raddr = src_q;
		low_we = 1'b0; low_waddr = cur_q; low_wdata = '0; low_raddr = cur_q;
		comp_we = 1'b0; comp_waddr = cur_q; comp_wdata = '0; comp_raddr = emit_q[NodeW-1:0];
		pend_we = 1'b0; pend_waddr = pd_idx; pend_wdata = enter_node_q; pend_raddr = pd_m1;
		frm_we = 1'b0; frm_waddr = fd_m1; frm_wdata = '0; frm_raddr = fd_m1;
		if (enter_q) begin
			low_we = 1'b1;
			low_waddr = enter_node_q;
			low_wdata = visit_q;
			pend_we = 1'b1;
			frm_we = 1'b1;
			frm_waddr = fd_idx;
			frm_wdata = {enter_node_q, count_t'(0), visit_q};
		end
		case (state_q)
			ST_ADD_WR: begin
				adj_we = 1'b1;
				adj_waddr = src_q;
				adj_wdata = (row_valid_q[src_q] ? adj_rdata : '0) | (row_t'(1) << dst_q);
			end
			ST_SCAN: begin
				adj_raddr = cur_q;
				low_raddr = found_q;
				if (!enter_q && next_q < n_eff) begin
					frm_we = 1'b0;
				end
			end
			ST_FRAME: begin
				adj_raddr = cur_q;
				low_raddr = cur_q;
			end
			ST_LOW_RD: begin
				// neighbour found: its order; scan done: the current node's
				low_raddr = (scan_q != '0) ? found_q : cur_q;
			end
			ST_LOW_CMP: begin
				if (scan_q != '0) begin
					frm_we = 1'b1;
					frm_waddr = fd_m1;
					frm_wdata = {cur_q, next_q,
						(visited_q[found_q] && low_rdata < fmin_q) ? low_rdata : fmin_q};
				end
			end
			ST_FIN: begin
				if (fmin_q < lowv_q) begin
					low_we = 1'b1;
					low_waddr = cur_q;
					low_wdata = fmin_q;
				end
			end
			ST_POP_WR: begin
				comp_we = 1'b1;
				comp_waddr = pend_rdata;
				comp_wdata = comp_q[NodeW-1:0];
				low_we = 1'b1;
				low_waddr = pend_rdata;
				low_wdata = n_eff;
			end
			ST_RET: begin
				if (scan_q == count_t'(7) && fdepth_q != '0) begin
					frm_we = 1'b1;
					frm_waddr = fd_m1;
					frm_wdata = {top_node, top_next, (lowv_q < top_min) ? lowv_q : top_min};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			node_count_q <= count_t'(MaxNodes);
			row_valid_q <= '0;
			visited_q <= '0;
			visit_q <= '0;
			comp_q <= '0;
			fdepth_q <= '0;
			pdepth_q <= '0;
			root_q <= '0;
			scan_q <= '0;
			emit_q <= '0;
			next_q <= '0;
			enter_q <= 1'b0;
			enter_node_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			cur_q <= '0;
			fmin_q <= '0;
			found_q <= '0;
			lowv_q <= '0;
			row_q <= '0;
			out_valid <= 1'b0;
			node_index <= '0;
			component_id <= '0;
			component_total <= '0;
			last <= 1'b0;
		end else begin
			enter_q <= ((state_q == ST_ROOT) && (root_q < n_eff)
					&& !visited_q[root_q[NodeW-1:0]])
				|| ((state_q == ST_LOW_CMP) && (scan_q != '0) && !visited_q[found_q]);
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (out_xfer && !emit_fire) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						src_q <= source_node;
						dst_q <= target_node;
						case (command)
							CMD_CLEAR: state_q <= ST_CLEAR;
							CMD_ADD_EDGE: begin
								if (count_t'(source_node) < n_eff
										&& count_t'(target_node) < n_eff) begin
									state_q <= ST_ADD_RD;
								end
							end
							CMD_RUN: begin
								visited_q <= '0;
								visit_q <= '0;
								comp_q <= '0;
								fdepth_q <= '0;
								pdepth_q <= '0;
								root_q <= '0;
								state_q <= ST_ROOT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLEAR: begin
					row_valid_q <= '0;
					state_q <= ST_IDLE;
				end
				ST_ADD_RD: state_q <= ST_ADD_WR;
				ST_ADD_WR: begin
					row_valid_q[src_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_ROOT: begin
					if (root_q >= n_eff) begin
						emit_q <= '0;
						state_q <= ST_EMIT_RD;
					end else if (visited_q[root_q[NodeW-1:0]]) begin
						root_q <= root_q + count_t'(1);
					end else begin
						enter_node_q <= root_q[NodeW-1:0];
						visited_q[root_q[NodeW-1:0]] <= 1'b1;
						root_q <= root_q + count_t'(1);
						state_q <= ST_FRAME;
					end
				end
				ST_FRAME: begin
					// entry write lands this cycle; bump depths, then read top
					if (enter_q) begin
						visit_q <= visit_q + count_t'(1);
						fdepth_q <= fdepth_q + count_t'(1);
						pdepth_q <= pdepth_q + count_t'(1);
						state_q <= ST_FRAME;
					end else if (fdepth_q == '0) begin
						state_q <= ST_ROOT;
					end else begin
						state_q <= ST_SCAN;
						scan_q <= '0;
					end
				end
				ST_SCAN: begin
					// frame read returns now; hold its fields and fetch its row
					if (scan_q == '0) begin
						cur_q <= top_node;
						next_q <= top_next;
						fmin_q <= top_min;
						scan_q <= count_t'(1);
					end else if (scan_q == count_t'(1)) begin
						scan_q <= count_t'(2);
					end else if (scan_q == count_t'(2)) begin
						row_q <= row_eff;
						scan_q <= count_t'(3);
					end else if (next_q >= n_eff) begin
						lowv_q <= '0;
						state_q <= ST_LOW_RD;
						scan_q <= '0;
					end else if (row_q[next_q[NodeW-1:0]]) begin
						found_q <= next_q[NodeW-1:0];
						next_q <= next_q + count_t'(1);
						state_q <= ST_LOW_RD;
						scan_q <= count_t'(1);
					end else begin
						next_q <= next_q + count_t'(1);
					end
				end
				ST_LOW_RD: begin
					state_q <= ST_LOW_CMP;
				end
				ST_LOW_CMP: begin
					if (scan_q == '0) begin
						// neighbours exhausted; low_rdata is lowest order of cur
						lowv_q <= low_rdata;
						state_q <= ST_FIN;
					end else if (!visited_q[found_q]) begin
						enter_node_q <= found_q;
						visited_q[found_q] <= 1'b1;
						state_q <= ST_FRAME;
					end else begin
						state_q <= ST_FRAME;
					end
				end
				ST_FIN: begin
					if (fmin_q < lowv_q) begin
						lowv_q <= fmin_q;
						fdepth_q <= fdepth_q - count_t'(1);
						state_q <= ST_RET;
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					state_q <= ST_POP_WR;
				end
				ST_POP_WR: begin
					pdepth_q <= pdepth_q - count_t'(1);
					if (pend_rdata == cur_q || pdepth_q == count_t'(1)) begin
						comp_q <= comp_q + count_t'(1);
						lowv_q <= n_eff;
						fdepth_q <= fdepth_q - count_t'(1);
						state_q <= ST_RET;
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_RET: begin
					// reads the parent frame first, then folds the min in
					if (scan_q != count_t'(7)) begin
						scan_q <= count_t'(7);
					end else begin
						state_q <= ST_FRAME;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						out_valid <= 1'b1;
						node_index <= emit_q[NodeW-1:0];
						component_id <= comp_rdata;
						component_total <= comp_q;
						last <= (emit_q + count_t'(1) == n_eff);
						emit_q <= emit_q + count_t'(1);
						state_q <= (emit_q + count_t'(1) == n_eff) ? ST_IDLE : ST_EMIT_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/scc_checker.sv]
// Port-level checks for the strongly connected components core, with bind.
`default_nettype none
module scc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic last,
	input wire logic [5:0] node_index,
	input wire logic cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(node_index) && $stable(last))
		else $error("stalled result changed");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !out_valid)
		else $error("config ready while a result waits");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
			!out_valid || node_index == $past(node_index) + 6'd1)
		else $error("result order");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid)
		else $error("result after last");
endmodule
bind strongly_connected_components_core scc_checker u_scc_checker (.clk(clk),
	.arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall), .last(last),
	.node_index(node_index), .cfg_ready(cfg_ready));
`default_nettype wire
